>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned PriorityW = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned StatusW   = 2;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

>>> hw/rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [ValueW-1:0]    item_value;
  logic        [PriorityW-1:0] item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [ValueW-1:0]    head_value;
  logic        [PriorityW-1:0] head_priority;
  logic                        head_valid;
  logic        [CountW-1:0]    entry_count;
  logic        [StatusW-1:0]   status;

  modport source (output valid, head_value, head_priority, head_valid, entry_count, status,
                  input ready);
  modport sink   (input valid, head_value, head_priority, head_valid, entry_count, status,
                  output ready);
endinterface

>>> hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue held in sorted order in a row of shifting cells.
//
// Input channel in_i carries one command per transaction: enqueue a value
// with a priority, or dequeue the head. Output channel out_o returns one
// result per command: head value and priority after the command, a head
// valid flag, the entry count and a status (done, full reject, empty).
// Every cell compares its priority with the incoming one and, in the same
// cycle, holds, takes the new entry or shifts from a neighbor, so a command
// is applied on acceptance and its result is presented on the next cycle.
// The result sits in the queue state plus a status register; in_i.ready is
// high while no result is pending or the pending one is being taken, so one
// command per cycle is sustained while out_o.ready stays high. A stalled
// receiver holds back new commands and the result stays stable.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared and are never presented before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned VExtW = (VALUE_BITS > ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned PExtW = (PRIORITY_BITS > PriorityW) ? PRIORITY_BITS : PriorityW;
  localparam int unsigned CExtW = (CntW > CountW) ? CntW : CountW;

  logic [CntW-1:0]          count_q, count_d;
  spq_status_e              status_q, status_d;
  logic                     out_valid_q;
  logic                     accept;
  logic                     full, empty;
  spq_op_t                  op;

  logic [VExtW-1:0]         in_value_ext;
  logic [PExtW-1:0]         in_priority_ext;
  logic [VALUE_BITS-1:0]    new_value;
  logic [PRIORITY_BITS-1:0] new_priority;

  logic [VALUE_BITS-1:0]    cell_value    [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_priority [CAPACITY];
  logic                     cell_keep     [CAPACITY];

  logic [VExtW-1:0]         head_value_ext;
  logic [PExtW-1:0]         head_priority_ext;
  logic [CExtW-1:0]         count_ext;

  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;

  assign op.enq = accept && (in_i.cmd == CMD_ENQUEUE) && !full;
  assign op.deq = accept && (in_i.cmd == CMD_DEQUEUE) && !empty;

  assign in_value_ext    = VExtW'($unsigned(in_i.item_value));
  assign in_priority_ext = PExtW'(in_i.item_priority);
  assign new_value       = in_value_ext[VALUE_BITS-1:0];
  assign new_priority    = in_priority_ext[PRIORITY_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_keep;
    logic [VALUE_BITS-1:0]    left_value, right_value;
    logic [PRIORITY_BITS-1:0] left_priority, right_priority;

    if (i == 0) begin : g_first
      assign prev_keep     = 1'b1;
      assign left_value    = new_value;
      assign left_priority = new_priority;
    end else begin : g_inner_left
      assign prev_keep     = cell_keep[i-1];
      assign left_value    = cell_value[i-1];
      assign left_priority = cell_priority[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value    = '0;
      assign right_priority = '0;
    end else begin : g_inner_right
      assign right_value    = cell_value[i+1];
      assign right_priority = cell_priority[i+1];
    end

    spq_cell #(
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i            (clk_i),
      .op_i             (op),
      .occupied_i       (count_q > CntW'(i)),
      .prev_keep_i      (prev_keep),
      .new_value_i      (new_value),
      .new_priority_i   (new_priority),
      .left_value_i     (left_value),
      .left_priority_i  (left_priority),
      .right_value_i    (right_value),
      .right_priority_i (right_priority),
      .keep_o           (cell_keep[i]),
      .value_o          (cell_value[i]),
      .priority_o       (cell_priority[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      status_d = STATUS_DONE;
      if (in_i.cmd == CMD_ENQUEUE) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign head_value_ext    = VExtW'(cell_value[0]);
  assign head_priority_ext = PExtW'(cell_priority[0]);
  assign count_ext         = CExtW'(count_q);

  assign out_o.valid         = out_valid_q;
  assign out_o.head_value    = empty ? '0 : $signed(head_value_ext[ValueW-1:0]);
  assign out_o.head_priority = empty ? '0 : head_priority_ext[PriorityW-1:0];
  assign out_o.head_valid    = !empty;
  assign out_o.entry_count   = count_ext[CountW-1:0];
  assign out_o.status        = status_q;

endmodule

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot. Holds, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                     clk_i,
  input  spq_pkg::spq_op_t         op_i,
  input  logic                     occupied_i,
  input  logic                     prev_keep_i,
  input  logic [VALUE_BITS-1:0]    new_value_i,
  input  logic [PRIORITY_BITS-1:0] new_priority_i,
  input  logic [VALUE_BITS-1:0]    left_value_i,
  input  logic [PRIORITY_BITS-1:0] left_priority_i,
  input  logic [VALUE_BITS-1:0]    right_value_i,
  input  logic [PRIORITY_BITS-1:0] right_priority_i,
  output logic                     keep_o,
  output logic [VALUE_BITS-1:0]    value_o,
  output logic [PRIORITY_BITS-1:0] priority_o
);
  import spq_pkg::*;

  logic [VALUE_BITS-1:0]    value_q, value_d;
  logic [PRIORITY_BITS-1:0] priority_q, priority_d;

  // Entries of equal or higher priority stay ahead of a new one.
  assign keep_o = occupied_i && (priority_q >= new_priority_i);

  always_comb begin
    value_d    = value_q;
    priority_d = priority_q;
    if (op_i.enq) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          value_d    = new_value_i;
          priority_d = new_priority_i;
        end else begin
          value_d    = left_value_i;
          priority_d = left_priority_i;
        end
      end
    end else if (op_i.deq) begin
      value_d    = right_value_i;
      priority_d = right_priority_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    priority_q <= priority_d;
  end

  assign value_o    = value_q;
  assign priority_o = priority_q;

endmodule

>>> sim/sorted_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Self-checking testbench for the sorted priority queue core.
//
// A behavioral copy of the sorted store predicts the head, count and status
// that every accepted command returns. A checker process compares each
// returned transaction against the oldest pending prediction. A short
// directed sequence covers the empty dequeue, field extremes, equal priority
// ordering and the full reject. Randomized traffic then picks at random
// between fill-heavy, drain-heavy and balanced stretches, so the queue is
// driven to full and to empty many times. This traffic runs with no idling,
// with sender gaps, with receiver stalls and with both.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic signed [ValueW-1:0]    value;
    logic        [PriorityW-1:0] prio;
    logic                        valid;
    logic        [CountW-1:0]    count;
    spq_status_e                 status;
  } head_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  sorted_priority_queue_core #(
    .CAPACITY     (Capacity),
    .VALUE_BITS   (ValueW),
    .PRIORITY_BITS(PriorityW)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [ValueW-1:0]    shadow_value [Capacity];
  logic        [PriorityW-1:0] shadow_prio  [Capacity];
  int unsigned                 shadow_count;
  head_result_t                pending_heads [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned enq_count;
  int unsigned deq_count;
  int unsigned full_count;
  int unsigned empty_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_heads.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_if.ready = ($urandom_range(99) >= stall_pct);
  end

  // Sorted insert behind equal or higher priorities, dequeue from slot 0.
  task automatic shadow_apply(input logic cmd, input logic signed [ValueW-1:0] value,
                              input logic [PriorityW-1:0] prio);
    head_result_t res;
    int unsigned  pos;
    int unsigned  k;
    res.status = STATUS_DONE;
    if (cmd == CMD_ENQUEUE) begin
      enq_count++;
      if (shadow_count >= Capacity) begin
        res.status = STATUS_FULL;
        full_count++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
        for (k = shadow_count; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else begin
      deq_count++;
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
        empty_count++;
      end else begin
        for (k = 1; k < shadow_count; k++) begin
          shadow_value[k-1] = shadow_value[k];
          shadow_prio[k-1]  = shadow_prio[k];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      res.value = shadow_value[0];
      res.prio  = shadow_prio[0];
      res.valid = 1'b1;
    end else begin
      res.value = '0;
      res.prio  = '0;
      res.valid = 1'b0;
    end
    res.count = shadow_count[CountW-1:0];
    pending_heads.push_back(res);
  endtask

  task automatic send_cmd(input logic cmd, input logic signed [ValueW-1:0] value,
                          input logic [PriorityW-1:0] prio);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid         = 1'b0;
      in_if.cmd           = 1'($urandom_range(1));
      in_if.item_value    = $urandom;
      in_if.item_priority = 8'($urandom);
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.cmd           = cmd;
    in_if.item_value    = value;
    in_if.item_priority = prio;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    shadow_apply(cmd, value, prio);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    head_result_t exp_head;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_heads.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("Unexpected result transaction: value %0d prio %0d count %0d",
                   out_if.head_value, out_if.head_priority, out_if.entry_count);
      end else begin
        exp_head = pending_heads.pop_front();
        checked_count++;
        if (out_if.head_value !== exp_head.value || out_if.head_priority !== exp_head.prio ||
            out_if.head_valid !== exp_head.valid || out_if.entry_count !== exp_head.count ||
            out_if.status !== exp_head.status) begin
          error_count++;
          if (error_count <= MaxReports)
            $display({"Mismatch on result %0d: exp value %0d prio %0d valid %0b count %0d ",
                      "status %s, got value %0d prio %0d valid %0b count %0d status %0d"},
                     checked_count, exp_head.value, exp_head.prio, exp_head.valid,
                     exp_head.count, exp_head.status.name(), out_if.head_value,
                     out_if.head_priority, out_if.head_valid, out_if.entry_count,
                     out_if.status);
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_cmd(CMD_DEQUEUE, 32'sd5, 8'd9);
    send_cmd(CMD_ENQUEUE, 32'sh7fffffff, 8'd0);
    send_cmd(CMD_ENQUEUE, 32'sh80000000, 8'd255);
    send_cmd(CMD_ENQUEUE, 32'sd0, 8'd128);
    send_cmd(CMD_ENQUEUE, -32'sd1, 8'd128);
    send_cmd(CMD_ENQUEUE, 32'sd11, 8'd255);
    send_cmd(CMD_ENQUEUE, 32'sd12, 8'd0);
    for (int i = 0; i < 10; i++) send_cmd(CMD_ENQUEUE, 32'sd100 + i, 8'(i % 3 + 127));
    send_cmd(CMD_ENQUEUE, 32'sh55555555, 8'd200);
    send_cmd(CMD_ENQUEUE, 32'shaaaaaaaa, 8'd255);
    for (int i = 0; i < 6; i++) send_cmd(CMD_DEQUEUE, $urandom, 8'($urandom));
    drain_results();
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned             enq_bias;
    int unsigned             prio_base;
    logic                    narrow;
    logic                    cmd;
    logic signed [ValueW-1:0] value;
    logic [PriorityW-1:0]    prio;
    enq_bias  = 50;
    prio_base = 0;
    narrow    = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_bias = 85;
          1:       enq_bias = 15;
          default: enq_bias = 50;
        endcase
        narrow    = 1'($urandom_range(1));
        prio_base = $urandom_range(1) ? 252 : 0;
      end
      cmd = ($urandom_range(99) < enq_bias) ? CMD_ENQUEUE : CMD_DEQUEUE;
      case ($urandom_range(15))
        0:       value = 32'sh80000000;
        1:       value = 32'sh7fffffff;
        2:       value = '0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase
      prio = narrow ? 8'(prio_base + $urandom_range(3)) : 8'($urandom);
      send_cmd(cmd, value, prio);
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    random_traffic(225);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 50;
    stall_pct = 0;
    random_traffic(225);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 50;
    random_traffic(225);
  endtask

  task automatic test_mixed_idling();
    idle_pct  = 30;
    stall_pct = 30;
    random_traffic(225);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.cmd           = CMD_ENQUEUE;
    in_if.item_value    = '0;
    in_if.item_priority = '0;
    out_if.ready        = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    shadow_count        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    $display("Checked %0d results: %0d enqueues (%0d rejected full), %0d dequeues (%0d empty)",
             checked_count, enq_count, full_count, deq_count, empty_count);
    $display("Traffic ran back to back, with sender gaps, receiver stalls and both mixed");
    if (error_count == 0 && pending_heads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
sim/sorted_priority_queue_core_test.sv
